// File: rtl/core/dmne_pkg.sv
package dmne_pkg;

    localparam int DMNE_CHANNEL_COUNT = 64;
    localparam int CHAN_W             = 6;
    localparam int MODE_W             = 3;
    localparam int COUNT_W            = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC      = 3'd0,
        MODE_MARK_DEP   = 3'd1,
        MODE_CLEAR_ROW  = 3'd2,
        MODE_MARK_DIRTY = 3'd3,
        MODE_SET_NOTIFY = 3'd4,
        MODE_SCAN       = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN
    } state_t;

    typedef enum logic {
        KIND_ALLOC  = 1'b0,
        KIND_NOTIFY = 1'b1
    } kind_t;

endpackage

// File: rtl/core/dependency_mask_notify_engine_core.sv
// Dependency mask notify engine. Rows of the downstream matrix sit in a
// one-port-read, one-port-write synchronous memory; the dirty mask, notify mask
// and allocation count sit in flip-flops. Allocate, mark dependency and mark
// dirty go through a second state (row read, then row write-back or dirty-mask
// merge), and so does a mark dependency whose drain alone is out of range;
// clear row, set notify, unused modes, an out-of-range source channel, a scan
// before any allocation and a scan with nothing pending finish in the idle
// state. A scan emits one word per channel both dirty and notified, lowest
// channel first. Results leave through an output register, which takes a new
// word while the old one is taken; an allocation answer or a scan word waits
// while that register is held. Reset is immediate: each row has a valid flag
// in flip-flops and an unwritten row reads as zero, so there is no clearing
// pass. Channels at or above min(CHANNEL_COUNT, 64) are ignored.
module dependency_mask_notify_engine_core
    import dmne_pkg::*;
#(
    parameter int CHANNEL_COUNT = DMNE_CHANNEL_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [CHAN_W-1:0] chan_first,
    input  logic [CHAN_W-1:0] chan_second,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [CHAN_W-1:0] chan_out,
    output logic              full_error,
    output logic              last_of_run
);

    localparam int CAP   = (CHANNEL_COUNT < 64) ? CHANNEL_COUNT : 64;
    localparam int ROW_W = $clog2(CAP);

    typedef logic [CAP-1:0] row_t;

    row_t mem [CAP];

    state_t               state_reg, state_next;
    mode_t                op_mode_reg, op_mode_next;
    logic [ROW_W-1:0]     op_a_reg, op_a_next;
    logic [ROW_W-1:0]     op_b_reg, op_b_next;
    logic                 op_ok_reg, op_ok_next;
    row_t                 row_valid_reg, row_valid_next;
    row_t                 dirty_reg, dirty_next;
    row_t                 notify_reg, notify_next;
    row_t                 scan_reg, scan_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    row_t                 rd_row_reg;
    logic                 rd_valid_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    logic [CHAN_W-1:0]    chan_reg, chan_next;
    logic                 full_reg, full_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 out_free;
    logic                 a_ok, b_ok, alloc_ok;
    mode_t                mode_in;
    row_t                 pending;
    row_t                 row_eff;
    row_t                 scan_iso;
    row_t                 scan_rest;
    logic [ROW_W-1:0]     scan_idx;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    row_t                 wr_data;

    assign mode_in   = mode_t'(mode);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign a_ok      = {1'b0, chan_first}  < (CHAN_W+1)'(CAP);
    assign b_ok      = {1'b0, chan_second} < (CHAN_W+1)'(CAP);
    assign alloc_ok  = ({1'b0, count_reg} + (COUNT_W+1)'(1)) < (COUNT_W+1)'(CAP);
    assign pending   = dirty_reg & notify_reg;
    assign row_eff   = rd_valid_reg ? rd_row_reg : '0;
    assign scan_iso  = scan_reg & (~scan_reg + row_t'(1));
    assign scan_rest = scan_reg & ~scan_iso;

    always_comb
    begin
        scan_idx = '0;
        for (int j = 0; j < ROW_W; j++)
        begin
            for (int i = 0; i < CAP; i++)
            begin
                if (((i >> j) & 1) == 1)
                begin
                    scan_idx[j] = scan_idx[j] | scan_iso[i];
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (mode_in == MODE_ALLOC)
                    begin
                        state_next = ST_MOD;
                    end
                    else if ((mode_in == MODE_MARK_DEP || mode_in == MODE_MARK_DIRTY) && a_ok)
                    begin
                        state_next = ST_MOD;
                    end
                    else if (mode_in == MODE_SCAN && count_reg != '0 && pending != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MOD:
            begin
                if (op_mode_reg != MODE_ALLOC || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (out_free && scan_rest == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        op_mode_next   = op_mode_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        op_ok_next     = op_ok_reg;
        row_valid_next = row_valid_reg;
        dirty_next     = dirty_reg;
        notify_next    = notify_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        chan_next      = chan_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        rd_addr        = chan_first[ROW_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = op_a_reg;
        wr_data        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_mode_next = mode_in;
                    op_a_next    = chan_first[ROW_W-1:0];
                    op_b_next    = chan_second[ROW_W-1:0];
                    op_ok_next   = a_ok && b_ok;
                    unique case (mode_in)
                        MODE_ALLOC:
                        begin
                            op_a_next  = count_reg[ROW_W-1:0];
                            op_ok_next = alloc_ok;
                            rd_en      = 1'b1;
                            rd_addr    = count_reg[ROW_W-1:0];
                        end
                        MODE_MARK_DEP, MODE_MARK_DIRTY:
                        begin
                            rd_en = a_ok;
                        end
                        MODE_CLEAR_ROW:
                        begin
                            if (a_ok)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = chan_first[ROW_W-1:0];
                                wr_data = '0;
                                row_valid_next[chan_first[ROW_W-1:0]] = 1'b1;
                            end
                        end
                        MODE_SET_NOTIFY:
                        begin
                            if (a_ok)
                            begin
                                notify_next[chan_first[ROW_W-1:0]] = 1'b1;
                            end
                        end
                        MODE_SCAN:
                        begin
                            if (count_reg != '0)
                            begin
                                scan_next  = pending;
                                dirty_next = dirty_reg & ~pending;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                unique case (op_mode_reg)
                    MODE_ALLOC:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_ALLOC;
                            last_next      = 1'b1;
                            full_next      = !op_ok_reg;
                            chan_next      = op_ok_reg ? CHAN_W'(op_a_reg) : '0;
                            if (op_ok_reg)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                                wr_en      = 1'b1;
                                wr_data    = row_eff | (row_t'(1) << op_a_reg);
                                row_valid_next[op_a_reg] = 1'b1;
                            end
                        end
                    end
                    MODE_MARK_DEP:
                    begin
                        if (op_ok_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_data = row_eff | (row_t'(1) << op_b_reg);
                            row_valid_next[op_a_reg] = 1'b1;
                        end
                    end
                    MODE_MARK_DIRTY:
                    begin
                        dirty_next = dirty_reg | row_eff;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_NOTIFY;
                    chan_next      = CHAN_W'(scan_idx);
                    full_next      = 1'b0;
                    last_next      = (scan_rest == '0);
                    scan_next      = scan_rest;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            dirty_reg     <= '0;
            notify_reg    <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            dirty_reg     <= dirty_next;
            notify_reg    <= notify_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg <= op_mode_next;
        op_a_reg    <= op_a_next;
        op_b_reg    <= op_b_next;
        op_ok_reg   <= op_ok_next;
        kind_reg    <= kind_next;
        chan_reg    <= chan_next;
        full_reg    <= full_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_row_reg   <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign chan_out    = chan_reg;
    assign full_error  = full_reg;
    assign last_of_run = last_reg;

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_reg != '0)
        else $error("scan state with no pending channel");

    a_count_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < (COUNT_W+1)'(CAP))
        else $error("allocation count reached capacity");

    a_alloc_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_ALLOC |-> last_reg)
        else $error("allocation answer not marked last");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && full_reg |-> kind_reg == KIND_ALLOC && chan_reg == '0)
        else $error("full flag on a malformed word");

    a_scan_drains: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && out_free |=> (scan_reg & $past(scan_iso)) == '0)
        else $error("emitted channel not dropped from scan set");

endmodule

// File: bench/dmne_checker.sv
`timescale 1ns / 1ps

module dmne_checker
    import dmne_pkg::*;
#(
    parameter int CHANNEL_COUNT = DMNE_CHANNEL_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [CHAN_W-1:0] chan_first,
    input  logic [CHAN_W-1:0] chan_second,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              result_kind,
    input  logic [CHAN_W-1:0] chan_out,
    input  logic              full_error,
    input  logic              last_of_run,
    output int                fail_count,
    output int                pending_count,
    output int                notify_count,
    output int                refused_count
);

    localparam int CAP = (CHANNEL_COUNT < 64) ? CHANNEL_COUNT : 64;

    typedef struct packed {
        kind_t             kind;
        logic [CHAN_W-1:0] chan;
        logic              full;
        logic              last;
    } result_word_t;

    logic [63:0]        downstream [64];
    logic [63:0]        dirty_bits;
    logic [63:0]        notify_bits;
    logic [COUNT_W-1:0] alloc_cnt;
    result_word_t       expected_q [$];
    int                 errors = 0;
    int                 notified = 0;
    int                 refused = 0;

    function automatic bit chan_usable(input logic [CHAN_W-1:0] c);
        return int'(c) < CAP;
    endfunction

    task automatic predict_word(input logic [MODE_W-1:0] m,
                                input logic [CHAN_W-1:0] a,
                                input logic [CHAN_W-1:0] b);
        logic [63:0]       hits;
        logic [CHAN_W-1:0] id;
        result_word_t      w;
        case (m)
            MODE_ALLOC:
            begin
                w.kind = KIND_ALLOC;
                w.last = 1'b1;
                if (int'(alloc_cnt) + 1 < CAP)
                begin
                    id = alloc_cnt[CHAN_W-1:0];
                    alloc_cnt = alloc_cnt + COUNT_W'(1);
                    downstream[id][id] = 1'b1;
                    w.chan = id;
                    w.full = 1'b0;
                end
                else
                begin
                    w.chan = '0;
                    w.full = 1'b1;
                end
                expected_q.push_back(w);
            end
            MODE_MARK_DEP:
            begin
                if (chan_usable(a) && chan_usable(b))
                    downstream[a][b] = 1'b1;
            end
            MODE_CLEAR_ROW:
            begin
                if (chan_usable(a))
                    downstream[a] = '0;
            end
            MODE_MARK_DIRTY:
            begin
                if (chan_usable(a))
                    dirty_bits = dirty_bits | downstream[a];
            end
            MODE_SET_NOTIFY:
            begin
                if (chan_usable(a))
                    notify_bits[a] = 1'b1;
            end
            MODE_SCAN:
            begin
                if (alloc_cnt != '0)
                begin
                    hits = dirty_bits & notify_bits;
                    for (int i = 0; i < 64; i++)
                    begin
                        if (hits[i])
                        begin
                            w.kind = KIND_NOTIFY;
                            w.chan = CHAN_W'(i);
                            w.full = 1'b0;
                            w.last = ((hits >> (i + 1)) == 64'd0);
                            expected_q.push_back(w);
                        end
                    end
                    dirty_bits = dirty_bits & ~hits;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_word_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < 64; r++)
                downstream[r] = '0;
            dirty_bits = '0;
            notify_bits = '0;
            alloc_cnt = '0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word kind=%0d chan=%0d full=%0d last=%0d",
                             $time, result_kind, chan_out, full_error, last_of_run);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result_kind !== want.kind || chan_out !== want.chan ||
                        full_error !== want.full || last_of_run !== want.last)
                    begin
                        errors++;
                        $display("%0t: exp k=%0d c=%0d f=%0d l=%0d, got k=%0d c=%0d f=%0d l=%0d",
                                 $time, want.kind, want.chan, want.full, want.last,
                                 result_kind, chan_out, full_error, last_of_run);
                    end
                    if (want.kind == KIND_NOTIFY)
                        notified++;
                    if (want.full)
                        refused++;
                end
            end
            if (in_valid && in_ready)
                predict_word(mode, chan_first, chan_second);
        end
        fail_count    <= errors;
        pending_count <= expected_q.size();
        notify_count  <= notified;
        refused_count <= refused;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dmne_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int TOTAL_WORDS    = 410;
    localparam int HOLD_AFTER     = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode = '0;
    logic [CHAN_W-1:0] chan_first = '0;
    logic [CHAN_W-1:0] chan_second = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              result_kind;
    logic [CHAN_W-1:0] chan_out;
    logic              full_error;
    logic              last_of_run;

    int errors;
    int pending;
    int notified;
    int refused;
    int words_out = 0;
    int sent = 0;
    bit sender_eager = 1'b0;

    dependency_mask_notify_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .chan_first  (chan_first),
        .chan_second (chan_second),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .chan_out    (chan_out),
        .full_error  (full_error),
        .last_of_run (last_of_run)
    );

    dmne_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .chan_first    (chan_first),
        .chan_second   (chan_second),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .chan_out      (chan_out),
        .full_error    (full_error),
        .last_of_run   (last_of_run),
        .fail_count    (errors),
        .pending_count (pending),
        .notify_count  (notified),
        .refused_count (refused)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            words_out <= words_out + 1;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return CHAN_W'($urandom_range(0, 7));
        if (r < 7)
            return CHAN_W'($urandom_range(56, 63));
        return CHAN_W'($urandom_range(0, 63));
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] m,
                             input logic [CHAN_W-1:0] a,
                             input logic [CHAN_W-1:0] b);
        int gap;
        gap = sender_eager ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        chan_first  <= a;
        chan_second <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // build downstream links from one source, notify some, then dirty and usually scan
    task automatic send_chain();
        logic [CHAN_W-1:0] src;
        logic [CHAN_W-1:0] drain;
        int                links;
        src   = pick_chan();
        links = $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 1)
            send_word(MODE_ALLOC, pick_chan(), pick_chan());
        repeat (links)
        begin
            drain = pick_chan();
            send_word(MODE_MARK_DEP, src, drain);
            if ($urandom_range(0, 2) != 0)
                send_word(MODE_SET_NOTIFY, drain, pick_chan());
        end
        if ($urandom_range(0, 4) == 0)
            send_word(MODE_CLEAR_ROW, src, pick_chan());
        send_word(MODE_MARK_DIRTY, src, pick_chan());
        if ($urandom_range(0, 5) != 0)
            send_word(MODE_SCAN, pick_chan(), pick_chan());
    endtask

    initial
    begin : receiver
        int run;
        int gap;
        bit held;
        run  = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && words_out >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                run = HOLD_CYCLES;
            end
            else if (run > 0)
                run--;
            else
            begin
                gap = out_ready ? idle_len() : 0;
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    run = gap - 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    run = $urandom_range(0, 40);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int choice;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(MODE_MARK_DEP, 6'd63, 6'd0);
        send_word(MODE_MARK_DEP, 6'd0, 6'd63);
        send_word(MODE_SET_NOTIFY, 6'd63, 6'd0);
        send_word(MODE_SET_NOTIFY, 6'd0, 6'd63);
        send_word(MODE_MARK_DIRTY, 6'd0, 6'd0);
        // scan before any allocation
        send_word(MODE_SCAN, 6'd0, 6'd0);
        send_word(MODE_ALLOC, 6'd63, 6'd63);
        send_word(MODE_MARK_DIRTY, 6'd0, 6'd0);
        send_word(MODE_SCAN, 6'd63, 6'd63);
        // scan with nothing pending
        send_word(MODE_SCAN, 6'd0, 6'd0);
        send_word(MODE_MARK_DIRTY, 6'd63, 6'd0);
        send_word(MODE_CLEAR_ROW, 6'd63, 6'd0);
        send_word(MODE_MARK_DIRTY, 6'd63, 6'd0);
        send_word(MODE_SCAN, 6'd0, 6'd0);
        send_word(MODE_SPARE_LO, 6'd63, 6'd63);
        send_word(MODE_SPARE_HI, 6'd0, 6'd0);
        send_word(MODE_ALLOC, 6'd0, 6'd0);
        send_word(MODE_MARK_DEP, 6'd1, 6'd42);
        send_word(MODE_MARK_DEP, 6'd1, 6'd21);
        send_word(MODE_SET_NOTIFY, 6'd42, 6'd21);
        send_word(MODE_SET_NOTIFY, 6'd21, 6'd42);
        send_word(MODE_SET_NOTIFY, 6'd1, 6'd0);
        send_word(MODE_MARK_DIRTY, 6'd1, 6'd63);
        send_word(MODE_SCAN, 6'd42, 6'd21);

        while (sent < TOTAL_WORDS)
        begin
            sender_eager = ($urandom_range(0, 3) == 0);
            choice = $urandom_range(0, 9);
            if (choice < 5)
                send_chain();
            else if (choice < 7)
            begin
                repeat ($urandom_range(3, 8))
                    send_word(MODE_ALLOC, pick_chan(), pick_chan());
            end
            else
                send_word(MODE_W'($urandom_range(0, 7)), CHAN_W'($urandom()),
                          CHAN_W'($urandom()));
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run drove %0d input words and took %0d result words.", sent, words_out);
        $display("Scans notified %0d channels; %0d allocations were refused as full.",
                 notified, refused);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
